### hw/rtl/sah_pkg.sv
// Shared constants, types and helpers for the swept box hit test pipeline.
// No dependencies; used by sah_div and swept_aabb_hit_test.
`default_nettype none
package sah_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TS_W      = 24;
  localparam int POS_W     = 32;
  localparam int SIZE_W    = 31;
  // slab edge minus ray start, exact
  localparam int DIFF_W    = 36;
  // numerator magnitude: |diff| scaled by 2^FRAC_BITS
  localparam int NUM_W     = DIFF_W + FRAC_BITS;
  // full velocity * time_step product, signed
  localparam int PROD_W    = POS_W + TS_W + 1;
  // displacement width (signed) and magnitude width
  localparam int D_W       = PROD_W - FRAC_BITS;
  // quotient bits kept; anything larger saturates
  localparam int Q_W       = 33;
  localparam int DIV_LAT   = Q_W + 1;
  // slab times carry two extra codes for unbounded axes
  localparam int T_W       = 34;

  localparam logic [TS_W-1:0] TS_RESET = TS_W'(1092);

  localparam logic signed [T_W-1:0] T_NEG_UNB = T_W'(-64'sd2147483649);
  localparam logic signed [T_W-1:0] T_POS_UNB = T_W'(64'sd2147483648);
  localparam logic signed [T_W-1:0] T_ONE     = T_W'(1) << FRAC_BITS;
  localparam logic signed [T_W-1:0] T_MIN_EXT = T_W'(-64'sd2147483648);

  localparam logic [1:0] NORM_POS  = 2'b01;
  localparam logic [1:0] NORM_NEG  = 2'b11;
  localparam logic [1:0] NORM_NONE = 2'b00;

  // per-transaction flags that ride alongside the dividers
  typedef struct packed {
    logic       vzero;
    logic       dz_x;
    logic       dz_y;
    logic       in_x;
    logic       in_y;
    logic       dneg_x;
    logic       dneg_y;
    logic [3:0] nneg;   // numerator signs: x lo, x hi, y lo, y hi
  } sb_t;

  // magnitude quotient plus sign -> saturated signed 32-bit time
  function automatic logic signed [31:0] sat_time(input logic [Q_W-1:0] q,
                                                  input logic ovf,
                                                  input logic neg);
    logic [Q_W-1:0] nq;
    nq = -q;
    if (neg) begin
      if (ovf || q > Q_W'(64'h80000000)) return 32'sh80000000;
      return nq[31:0];
    end else begin
      if (ovf || q > Q_W'(64'h7FFFFFFF)) return 32'sh7FFFFFFF;
      return q[31:0];
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/swept_aabb_hit_test.sv
// Swept box versus fixed box hit test, slab method, fully pipelined.
// Depends on sah_pkg and sah_div.
//
// One transaction per clock is accepted while in_stall is low; one result per
// transaction comes out, in order, after stages 1 and 2, the four parallel
// slab dividers (one quotient bit per stage), stage 3 and the output register.
// The whole pipe, including the output register, advances on a single enable:
// it moves whenever the output register is empty or being taken, so a
// downstream stall holds every stage in place.
// time_step is written through the cfg port (always ready) and should only
// change while no transaction is in flight.
`default_nettype none
module swept_aabb_hit_test import sah_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [TS_W-1:0]          cfg_time_step,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [POS_W-1:0]  in_mover_x,
  input  wire logic signed [POS_W-1:0]  in_mover_y,
  input  wire logic [SIZE_W-1:0]        in_mover_w,
  input  wire logic [SIZE_W-1:0]        in_mover_h,
  input  wire logic signed [POS_W-1:0]  in_velocity_x,
  input  wire logic signed [POS_W-1:0]  in_velocity_y,
  input  wire logic signed [POS_W-1:0]  in_target_x,
  input  wire logic signed [POS_W-1:0]  in_target_y,
  input  wire logic [SIZE_W-1:0]        in_target_w,
  input  wire logic [SIZE_W-1:0]        in_target_h,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_hit,
  output logic signed [1:0]             out_normal_x,
  output logic signed [1:0]             out_normal_y,
  output logic signed [31:0]            out_hit_time
);

  logic en;
  logic [TS_W-1:0] ts_r;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TS_RESET;
    end else if (cfg_valid) begin
      ts_r <= cfg_time_step;
    end
  end

  // ---- stage 1: slab edges relative to ray start, displacement products
  logic                       v1_r;
  logic signed [DIFF_W-1:0]   dxl_r, dxh_r, dyl_r, dyh_r;
  logic signed [PROD_W-1:0]   px_r, py_r;
  logic                       vz1_r;
  logic signed [DIFF_W-1:0]   dxl_nxt, dxh_nxt, dyl_nxt, dyh_nxt;

  always_comb begin
    // lo - start = target - mover - 2*half; hi - start adds both sizes
    dxl_nxt = DIFF_W'(in_target_x) - DIFF_W'(in_mover_x)
            - $signed({{(DIFF_W-SIZE_W){1'b0}}, in_mover_w[SIZE_W-1:1], 1'b0});
    dxh_nxt = dxl_nxt + $signed(DIFF_W'(in_target_w)) + $signed(DIFF_W'(in_mover_w));
    dyl_nxt = DIFF_W'(in_target_y) - DIFF_W'(in_mover_y)
            - $signed({{(DIFF_W-SIZE_W){1'b0}}, in_mover_h[SIZE_W-1:1], 1'b0});
    dyh_nxt = dyl_nxt + $signed(DIFF_W'(in_target_h)) + $signed(DIFF_W'(in_mover_h));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxl_r <= dxl_nxt;
      dxh_r <= dxh_nxt;
      dyl_r <= dyl_nxt;
      dyh_r <= dyh_nxt;
      px_r  <= PROD_W'(in_velocity_x * $signed({1'b0, ts_r}));
      py_r  <= PROD_W'(in_velocity_y * $signed({1'b0, ts_r}));
      vz1_r <= (in_velocity_x == '0) && (in_velocity_y == '0);
    end
  end

  // ---- stage 2: floor shift, magnitudes, flags
  logic signed [D_W-1:0] dx_w, dy_w;
  logic [DIFF_W-1:0]     axl_w, axh_w, ayl_w, ayh_w;
  logic                  v2_r;
  sb_t                   sb2_r, sb2_nxt;
  logic [NUM_W-1:0]      nxl_r, nxh_r, nyl_r, nyh_r;
  logic [D_W-1:0]        mdx_r, mdy_r;

  assign dx_w  = D_W'(px_r >>> FRAC_BITS);
  assign dy_w  = D_W'(py_r >>> FRAC_BITS);
  assign axl_w = dxl_r[DIFF_W-1] ? DIFF_W'(-dxl_r) : DIFF_W'(dxl_r);
  assign axh_w = dxh_r[DIFF_W-1] ? DIFF_W'(-dxh_r) : DIFF_W'(dxh_r);
  assign ayl_w = dyl_r[DIFF_W-1] ? DIFF_W'(-dyl_r) : DIFF_W'(dyl_r);
  assign ayh_w = dyh_r[DIFF_W-1] ? DIFF_W'(-dyh_r) : DIFF_W'(dyh_r);

  always_comb begin
    sb2_nxt.vzero  = vz1_r;
    sb2_nxt.dz_x   = (dx_w == '0);
    sb2_nxt.dz_y   = (dy_w == '0);
    // start inside slab: lo <= start <= hi
    sb2_nxt.in_x   = (dxl_r <= 0) && (dxh_r >= 0);
    sb2_nxt.in_y   = (dyl_r <= 0) && (dyh_r >= 0);
    sb2_nxt.dneg_x = dx_w[D_W-1];
    sb2_nxt.dneg_y = dy_w[D_W-1];
    sb2_nxt.nneg   = {dyh_r[DIFF_W-1], dyl_r[DIFF_W-1], dxh_r[DIFF_W-1], dxl_r[DIFF_W-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r <= sb2_nxt;
      nxl_r <= {axl_w, {FRAC_BITS{1'b0}}};
      nxh_r <= {axh_w, {FRAC_BITS{1'b0}}};
      nyl_r <= {ayl_w, {FRAC_BITS{1'b0}}};
      nyh_r <= {ayh_w, {FRAC_BITS{1'b0}}};
      mdx_r <= dx_w[D_W-1] ? D_W'(-dx_w) : D_W'(dx_w);
      mdy_r <= dy_w[D_W-1] ? D_W'(-dy_w) : D_W'(dy_w);
    end
  end

  // ---- divider stages, flags travel in a matching shift line
  logic [Q_W-1:0] qxl, qxh, qyl, qyh;
  logic           oxl, oxh, oyl, oyh;
  logic           vd_r  [0:DIV_LAT-1];
  sb_t            sbd_r [0:DIV_LAT-1];

  sah_div u_div_xl (.clk(clk), .en(en), .num(nxl_r), .den(mdx_r), .quo(qxl), .ovf(oxl));
  sah_div u_div_xh (.clk(clk), .en(en), .num(nxh_r), .den(mdx_r), .quo(qxh), .ovf(oxh));
  sah_div u_div_yl (.clk(clk), .en(en), .num(nyl_r), .den(mdy_r), .quo(qyl), .ovf(oyl));
  sah_div u_div_yh (.clk(clk), .en(en), .num(nyh_r), .den(mdy_r), .quo(qyh), .ovf(oyh));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) vd_r[i] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v2_r;
      for (int i = 1; i < DIV_LAT; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbd_r[0] <= sb2_r;
      for (int i = 1; i < DIV_LAT; i++) sbd_r[i] <= sbd_r[i-1];
    end
  end

  // ---- stage 3: sign, saturate, order entry/exit per axis
  sb_t                   sbq_w;
  logic signed [31:0]    txl_w, txh_w, tyl_w, tyh_w;
  logic signed [T_W-1:0] xin_nxt, xout_nxt, yin_nxt, yout_nxt;
  logic                  v3_r;
  sb_t                   sb3_r;
  logic signed [T_W-1:0] xin_r, xout_r, yin_r, yout_r;

  assign sbq_w = sbd_r[DIV_LAT-1];

  always_comb begin
    txl_w = sat_time(qxl, oxl, sbq_w.nneg[0] ^ sbq_w.dneg_x);
    txh_w = sat_time(qxh, oxh, sbq_w.nneg[1] ^ sbq_w.dneg_x);
    tyl_w = sat_time(qyl, oyl, sbq_w.nneg[2] ^ sbq_w.dneg_y);
    tyh_w = sat_time(qyh, oyh, sbq_w.nneg[3] ^ sbq_w.dneg_y);
    if (sbq_w.dz_x) begin
      xin_nxt  = T_NEG_UNB;
      xout_nxt = T_POS_UNB;
    end else if (txl_w > txh_w) begin
      xin_nxt  = T_W'(txh_w);
      xout_nxt = T_W'(txl_w);
    end else begin
      xin_nxt  = T_W'(txl_w);
      xout_nxt = T_W'(txh_w);
    end
    if (sbq_w.dz_y) begin
      yin_nxt  = T_NEG_UNB;
      yout_nxt = T_POS_UNB;
    end else if (tyl_w > tyh_w) begin
      yin_nxt  = T_W'(tyh_w);
      yout_nxt = T_W'(tyl_w);
    end else begin
      yin_nxt  = T_W'(tyl_w);
      yout_nxt = T_W'(tyh_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= vd_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb3_r  <= sbq_w;
      xin_r  <= xin_nxt;
      xout_r <= xout_nxt;
      yin_r  <= yin_nxt;
      yout_r <= yout_nxt;
    end
  end

  // ---- stage 4: combine axes, decide hit, output register
  logic signed [T_W-1:0] entry_w, leave_w;
  logic                  x_first_w, hit_w;
  logic                  out_valid_r, hit_r;
  logic [1:0]            nx_r, ny_r, nx_nxt, ny_nxt;
  logic [31:0]           time_r, time_nxt;

  always_comb begin
    x_first_w = xin_r > yin_r;
    entry_w   = x_first_w ? xin_r : yin_r;
    leave_w   = (xout_r < yout_r) ? xout_r : yout_r;
    hit_w     = !sb3_r.vzero
             && !(sb3_r.dz_x && !sb3_r.in_x)
             && !(sb3_r.dz_y && !sb3_r.in_y)
             && !(entry_w > leave_w) && !(leave_w < 0) && !(entry_w > T_ONE);
    nx_nxt    = NORM_NONE;
    ny_nxt    = NORM_NONE;
    time_nxt  = '0;
    if (hit_w) begin
      if (x_first_w) nx_nxt = sb3_r.dneg_x ? NORM_POS : NORM_NEG;
      else           ny_nxt = sb3_r.dneg_y ? NORM_POS : NORM_NEG;
      // only the low unbounded code can reach here out of range
      time_nxt = (entry_w < T_MIN_EXT) ? 32'h80000000 : entry_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_w;
      nx_r   <= nx_nxt;
      ny_r   <= ny_nxt;
      time_r <= time_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = hit_r;
  assign out_normal_x = nx_r;
  assign out_normal_y = ny_r;
  assign out_hit_time = time_r;

  // a hit names exactly one face
  a_one_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> ((out_normal_x != NORM_NONE) != (out_normal_y != NORM_NONE)))
    else $error("hit without exactly one face normal");

  // a miss carries zero fields
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_normal_x == NORM_NONE && out_normal_y == NORM_NONE
                               && out_hit_time == '0))
    else $error("miss with nonzero fields");

  // entry time of a hit never lies past the end of the step
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_hit_time <= (32'sd1 <<< FRAC_BITS)))
    else $error("hit time beyond one step");

endmodule
`default_nettype wire

### hw/rtl/sah_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on sah_pkg.
`default_nettype none
module sah_div import sah_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [D_W-1:0]   den,
  output logic      [Q_W-1:0]   quo,
  output logic                  ovf
);

  logic [D_W-1:0] rem_r [0:Q_W];
  logic [Q_W-1:0] lq_r  [0:Q_W];   // low numerator bits shift out, quotient bits shift in
  logic [D_W-1:0] den_r [0:Q_W];
  logic           ovf_r [0:Q_W];

  logic [NUM_W-Q_W-1:0] top_w;
  assign top_w = num[NUM_W-1:Q_W];

  // quotient >= 2^Q_W when the top bits already reach the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= D_W'(top_w);
      ovf_r[0] <= D_W'(top_w) >= den;
      lq_r[0]  <= num[Q_W-1:0];
      den_r[0] <= den;
    end
  end

  for (genvar i = 1; i <= Q_W; i++) begin : g_stage
    logic [D_W:0] sh_w;
    logic [D_W:0] df_w;
    logic         ge_w;
    assign sh_w = {rem_r[i-1], lq_r[i-1][Q_W-1]};
    assign df_w = sh_w - {1'b0, den_r[i-1]};
    assign ge_w = sh_w >= {1'b0, den_r[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge_w ? df_w[D_W-1:0] : sh_w[D_W-1:0];
        lq_r[i]  <= {lq_r[i-1][Q_W-2:0], ge_w};
        den_r[i] <= den_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
      end
    end
  end

  assign quo = lq_r[Q_W];
  assign ovf = ovf_r[Q_W];

endmodule
`default_nettype wire

### tb/swept_aabb_hit_test_tb.sv
// Self-checking testbench for swept_aabb_hit_test: directed and random box pairs.
// Depends on sah_pkg and the swept_aabb_hit_test RTL; needs no other files.
// The expected contact results are computed in the testbench and compared in order.
`default_nettype none
module swept_aabb_hit_test_tb;
  import sah_pkg::*;

  // One input transaction: moving box, its velocity, and the fixed target box.
  typedef struct packed {
    logic signed [POS_W-1:0] mover_x;
    logic signed [POS_W-1:0] mover_y;
    logic [SIZE_W-1:0]       mover_w;
    logic [SIZE_W-1:0]       mover_h;
    logic signed [POS_W-1:0] velocity_x;
    logic signed [POS_W-1:0] velocity_y;
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic [SIZE_W-1:0]       target_w;
    logic [SIZE_W-1:0]       target_h;
  } box_pair_t;

  // One result transaction.
  typedef struct packed {
    logic              hit;
    logic signed [1:0] normal_x;
    logic signed [1:0] normal_y;
    logic signed [31:0] hit_time;
  } contact_t;

  // Slab times live in 64 bits; one code below and one above the 32-bit range
  // mark an axis with zero displacement whose start lies inside the slab.
  localparam longint TIME_MAX = 64'sd2147483647;
  localparam longint TIME_MIN = -64'sd2147483648;
  localparam longint UNB_LO   = TIME_MIN - 1;
  localparam longint UNB_HI   = TIME_MAX + 1;
  localparam longint ONE      = 64'sd1 << FRAC_BITS;
  localparam int     LATENCY  = DIV_LAT + 4;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [TS_W-1:0] cfg_time_step;
  logic in_valid;
  logic in_stall;
  box_pair_t drv;
  logic out_valid;
  logic out_stall;
  logic out_hit;
  logic signed [1:0] out_normal_x;
  logic signed [1:0] out_normal_y;
  logic signed [31:0] out_hit_time;

  box_pair_t pending_pairs[$];
  contact_t  expected_contacts[$];
  logic [TS_W-1:0] step_model;   // testbench copy of time_step
  int  n_errors;
  int  n_results;
  bit  pair_taken;               // input transaction accepted at the last rising edge
  int  burst_left, gap_left;
  int  hold_left, pat_left, pat_mode;
  bit  hold_done;

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_time_step = '0;
    in_valid = 1'b0;
    drv = '0;
    out_stall = 1'b0;
    step_model = TS_RESET;
    n_errors = 0;
    n_results = 0;
    pair_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    hold_left = 0;
    pat_left = 0;
    pat_mode = 0;
    hold_done = 1'b0;
  end

  swept_aabb_hit_test i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_time_step (cfg_time_step),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mover_x    (drv.mover_x),
    .in_mover_y    (drv.mover_y),
    .in_mover_w    (drv.mover_w),
    .in_mover_h    (drv.mover_h),
    .in_velocity_x (drv.velocity_x),
    .in_velocity_y (drv.velocity_y),
    .in_target_x   (drv.target_x),
    .in_target_y   (drv.target_y),
    .in_target_w   (drv.target_w),
    .in_target_h   (drv.target_h),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_normal_x  (out_normal_x),
    .out_normal_y  (out_normal_y),
    .out_hit_time  (out_hit_time)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the pipe hangs.
  initial begin
    #5000000;
    $display("swept_aabb_hit_test_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(longint x);
    if (x > TIME_MAX) return TIME_MAX;
    if (x < TIME_MIN) return TIME_MIN;
    return x;
  endfunction

  // Entry/exit times of one axis; 0 when this axis alone rules out a hit.
  function automatic bit slab_times(longint lo, longint hi, longint start, longint d,
                                    output longint t_in, output longint t_out);
    longint a, b;
    if (d == 0) begin
      if (start < lo || start > hi) return 1'b0;
      t_in = UNB_LO;
      t_out = UNB_HI;
      return 1'b1;
    end
    // longint division truncates toward zero
    a = clamp32(((lo - start) * ONE) / d);
    b = clamp32(((hi - start) * ONE) / d);
    t_in  = (a > b) ? b : a;
    t_out = (a > b) ? a : b;
    return 1'b1;
  endfunction

  function automatic contact_t predict_contact(box_pair_t p, logic [TS_W-1:0] ts);
    contact_t r;
    longint mw, mh, hw, hh, dx, dy, x_in, x_out, y_in, y_out, t_entry, t_leave;
    r = '0;
    if (p.velocity_x == 0 && p.velocity_y == 0) return r;
    mw = longint'(p.mover_w);
    mh = longint'(p.mover_h);
    hw = mw >>> 1;
    hh = mh >>> 1;
    // arithmetic shift = floor for the displacement
    dx = (longint'(p.velocity_x) * longint'(ts)) >>> FRAC_BITS;
    dy = (longint'(p.velocity_y) * longint'(ts)) >>> FRAC_BITS;
    if (!slab_times(longint'(p.target_x) - hw,
                    longint'(p.target_x) - hw + longint'(p.target_w) + mw,
                    longint'(p.mover_x) + hw, dx, x_in, x_out)) return r;
    if (!slab_times(longint'(p.target_y) - hh,
                    longint'(p.target_y) - hh + longint'(p.target_h) + mh,
                    longint'(p.mover_y) + hh, dy, y_in, y_out)) return r;
    t_entry = (x_in > y_in) ? x_in : y_in;
    t_leave = (x_out < y_out) ? x_out : y_out;
    if (t_entry > t_leave || t_leave < 0 || t_entry > ONE) return r;
    r.hit = 1'b1;
    if (x_in > y_in) r.normal_x = (dx < 0) ? NORM_POS : NORM_NEG;
    else             r.normal_y = (dy < 0) ? NORM_POS : NORM_NEG;
    r.hit_time = 32'(clamp32(t_entry));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic box_pair_t mk(longint mx, longint my, longint mw, longint mh,
                                   longint vx, longint vy, longint tx, longint ty,
                                   longint tw, longint th);
    box_pair_t p;
    p.mover_x = 32'(mx);     p.mover_y = 32'(my);
    p.mover_w = 31'(mw);     p.mover_h = 31'(mh);
    p.velocity_x = 32'(vx);  p.velocity_y = 32'(vy);
    p.target_x = 32'(tx);    p.target_y = 32'(ty);
    p.target_w = 31'(tw);    p.target_h = 31'(th);
    return p;
  endfunction

  function automatic longint pick_extreme();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return -1;
      3: return TIME_MAX;
      4: return TIME_MIN;
      default: return ONE;
    endcase
  endfunction

  // Mostly boxes on a collision course (random content), some pure noise and
  // some collision-course cases with one field forced to an extreme or zero value.
  function automatic box_pair_t make_pair(logic [TS_W-1:0] ts);
    box_pair_t p;
    logic [319:0] noise;
    longint tx, ty, tw, th, mw, mh, ddx, ddy, vx, vy, fx, fy;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
      p = noise[$bits(box_pair_t)-1:0];
      return p;
    end
    tx = longint'($urandom_range(0, 200 << 16)) - (100 << 16);
    ty = longint'($urandom_range(0, 200 << 16)) - (100 << 16);
    tw = longint'($urandom_range(0, 20 << 16));
    th = longint'($urandom_range(0, 20 << 16));
    mw = longint'($urandom_range(0, 20 << 16));
    mh = longint'($urandom_range(0, 20 << 16));
    ddx = ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(0, 100 << 16)) - (50 << 16);
    ddy = ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(0, 100 << 16)) - (50 << 16);
    if (ts == 0) begin
      vx = longint'($signed($urandom));
      vy = longint'($signed($urandom));
    end else begin
      vx = clamp32((ddx * ONE) / longint'(ts));
      vy = clamp32((ddy * ONE) / longint'(ts));
    end
    // start between zero and one and a half steps before the target, with jitter
    fx = longint'($urandom_range(0, 6));
    fy = longint'($urandom_range(0, 6));
    p = mk(tx + tw / 2 - mw / 2 - ddx * fx / 4 + longint'($urandom_range(0, 8 << 16)) - (4 << 16),
           ty + th / 2 - mh / 2 - ddy * fy / 4 + longint'($urandom_range(0, 8 << 16)) - (4 << 16),
           mw, mh, vx, vy, tx, ty, tw, th);
    if (sel < 35) begin
      case ($urandom_range(0, 4))
        0: p.velocity_x = 32'(pick_extreme());
        1: p.velocity_y = 32'(pick_extreme());
        2: p.mover_x = 32'(pick_extreme());
        3: p.target_y = 32'(pick_extreme());
        default: p.velocity_x = '0;
      endcase
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of transactions with random gaps in between.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !pair_taken) begin
      // stalled: hold the payload
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_pairs.size() > 0) begin
      drv <= pending_pairs.pop_front();
      in_valid <= 1'b1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random patterns plus one long hold-off that fills the pipe.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_results >= 60) begin
      hold_done = 1'b1;
      hold_left = 150;
      out_stall <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 2);
        pat_left = $urandom_range(5, 50);
      end
      pat_left--;
      case (pat_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: config tracking, prediction on input accept, compare on output.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    contact_t exp_c;
    pair_taken = rst_n && in_valid && !in_stall;
    if (rst_n && cfg_valid && cfg_ready) step_model = cfg_time_step;
    if (pair_taken) expected_contacts.push_back(predict_contact(drv, step_model));
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_contacts.size() == 0) begin
        $error("unexpected result transaction");
        n_errors++;
      end else begin
        exp_c = expected_contacts.pop_front();
        if (out_hit !== exp_c.hit) begin
          $error("hit: expected %0d, got %0d", exp_c.hit, out_hit);
          n_errors++;
        end
        if (out_normal_x !== exp_c.normal_x) begin
          $error("normal_x: expected %0d, got %0d", exp_c.normal_x, out_normal_x);
          n_errors++;
        end
        if (out_normal_y !== exp_c.normal_y) begin
          $error("normal_y: expected %0d, got %0d", exp_c.normal_y, out_normal_y);
          n_errors++;
        end
        if (out_hit_time !== exp_c.hit_time) begin
          $error("hit_time: expected %0d, got %0d", exp_c.hit_time, out_hit_time);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid) @(posedge clk);
    while (expected_contacts.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_step(logic [TS_W-1:0] ts);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_time_step = ts;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(int count);
    repeat (count) pending_pairs.push_back(make_pair(step_model));
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed cases at the reset time step (displacement ~ velocity / 60).
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));                // zero velocity
    pending_pairs.push_back(mk(TIME_MAX, TIME_MAX, 31'h7fffffff, 31'h7fffffff,
                               TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                               31'h7fffffff, 31'h7fffffff));                   // all max
    pending_pairs.push_back(mk(TIME_MIN, TIME_MIN, 0, 0, TIME_MIN, TIME_MIN,
                               TIME_MIN, TIME_MIN, 0, 0));                     // all min
    // x displacement zero, start inside the x slab, falling onto the target
    pending_pairs.push_back(mk(0, -(20 << 16), 2 << 16, 2 << 16, 0, 1300 << 16,
                               0, 0, 4 << 16, 4 << 16));
    // x displacement zero, start outside the x slab
    pending_pairs.push_back(mk(50 << 16, -(20 << 16), 2 << 16, 2 << 16, 0, 1300 << 16,
                               0, 0, 4 << 16, 4 << 16));
    // y displacement zero, inside / outside the y slab
    pending_pairs.push_back(mk(-(20 << 16), 0, 2 << 16, 2 << 16, 1300 << 16, 0,
                               0, 0, 4 << 16, 4 << 16));
    pending_pairs.push_back(mk(-(20 << 16), 50 << 16, 2 << 16, 2 << 16, 1300 << 16, 0,
                               0, 0, 4 << 16, 4 << 16));
    // overlapping already and moving away: negative entry, still a hit
    pending_pairs.push_back(mk(1 << 16, 1 << 16, 2 << 16, 2 << 16, 600 << 16, -(600 << 16),
                               0, 0, 4 << 16, 4 << 16));
    // tiny velocity over a large distance: displacement floors to zero, a miss
    pending_pairs.push_back(mk(-(30000 << 16), 0, 0, 0, 60, 60, 30000 << 16, 0,
                               1 << 16, 1 << 16));
    // moving away from a distant target
    pending_pairs.push_back(mk(-(20 << 16), -(20 << 16), 2 << 16, 2 << 16,
                               -(1300 << 16), -(1300 << 16), 0, 0, 4 << 16, 4 << 16));
    // diagonal with equal axis entry times: normal goes to y
    pending_pairs.push_back(mk(-(10 << 16), -(10 << 16), 2 << 16, 2 << 16,
                               1300 << 16, 1300 << 16, 0, 0, 4 << 16, 4 << 16));
    // leftward and upward hits: positive normals
    pending_pairs.push_back(mk(20 << 16, 1 << 16, 2 << 16, 2 << 16, -(1300 << 16), 0,
                               0, 0, 4 << 16, 4 << 16));
    pending_pairs.push_back(mk(1 << 16, 20 << 16, 2 << 16, 2 << 16, 0, -(1300 << 16),
                               0, 0, 4 << 16, 4 << 16));
    // hit just beyond the end of the step
    pending_pairs.push_back(mk(-(40 << 16), 0, 2 << 16, 2 << 16, 1300 << 16, 0,
                               0, 0, 4 << 16, 4 << 16));
    // zero-sized boxes on a collision course
    pending_pairs.push_back(mk(-(5 << 16), 0, 0, 0, 1300 << 16, 1, 0, 0, 0, 0));
    drain();

    run_random(80);
    write_step(24'h010000);      // one second per step
    run_random(110);
    write_step('0);              // zero step: every displacement is zero
    run_random(40);
    write_step(24'hFFFFFF);      // largest step
    run_random(80);
    write_step(TS_W'($urandom));
    run_random(70);
    write_step(24'd1);
    run_random(40);

    if (n_errors == 0) begin
      $display("swept_aabb_hit_test_tb: done, clean");
    end else begin
      $display("swept_aabb_hit_test_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
